[sv/kms_pkg.sv]
// Shared types, constants and code tables for the keyboard matrix scanner.
// No dependencies; every other file but the interfaces and checker refers to it.
package kms_pkg;

    localparam int ROW_COUNT = 8;
    localparam int ROWS_USED = (ROW_COUNT > 8) ? 8 : ((ROW_COUNT < 1) ? 1 : ROW_COUNT);
    localparam int ROW_SLOTS = 8;
    localparam int ROW_W = 3;
    localparam int COL_W = 3;
    localparam int KEY_W = 6;
    localparam int ACC_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [COL_W-1:0] SHIFT_COL = 3'd2;
    localparam logic [KEY_W-1:0] KEY_SHIFT = 6'd2;
    localparam logic [KEY_W-1:0] KEY_FIRST_EXT = 6'd60;
    localparam logic [ACC_W-1:0] ACC_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTPUT_MODE   = 2'd0,
        CFG_REPEAT_DELAY  = 2'd1,
        CFG_REPEAT_PERIOD = 2'd2,
        CFG_TIME_STEP     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        output_mode;
        logic [11:0] repeat_delay;
        logic [11:0] repeat_period;
        logic [7:0]  time_step;
    } t_cfg;

    // One row scan handed from the front end to the back end. Bit c of
    // pressed is column c (the row's MSB is column 0).
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [7:0]       pressed;
    } t_q_entry;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic             is_break;
        logic [7:0]       scan_code;
        logic             extended;
        logic             send_scan;
        logic [7:0]       ascii_code;
        logic             last_event;
    } t_event;

    // Character table: entry key*2 is the plain character, key*2+1 the shifted one.
    localparam logic [7:0] ASCII_TABLE [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h31, 8'h21,
        8'h51, 8'h71, 8'h41, 8'h61, 8'h5A, 8'h7A, 8'h00, 8'h00,
        8'h33, 8'h23, 8'h32, 8'h22, 8'h45, 8'h65, 8'h57, 8'h77,
        8'h44, 8'h64, 8'h53, 8'h73, 8'h43, 8'h63, 8'h58, 8'h78,
        8'h35, 8'h25, 8'h34, 8'h24, 8'h54, 8'h74, 8'h52, 8'h72,
        8'h47, 8'h67, 8'h46, 8'h66, 8'h42, 8'h62, 8'h56, 8'h76,
        8'h37, 8'h27, 8'h36, 8'h26, 8'h55, 8'h75, 8'h59, 8'h79,
        8'h4A, 8'h6A, 8'h48, 8'h68, 8'h4D, 8'h6D, 8'h4E, 8'h6E,
        8'h39, 8'h29, 8'h38, 8'h28, 8'h4F, 8'h6F, 8'h49, 8'h69,
        8'h4C, 8'h6C, 8'h4B, 8'h6B, 8'h2E, 8'h3E, 8'h2C, 8'h3C,
        8'h2D, 8'h3D, 8'h30, 8'h30, 8'h40, 8'h60, 8'h50, 8'h70,
        8'h3A, 8'h2A, 8'h3B, 8'h2B, 8'h5F, 8'h5F, 8'h2F, 8'h3F,
        8'h5E, 8'h7E, 8'h5C, 8'h7C, 8'h5B, 8'h7B, 8'h08, 8'h00,
        8'h5D, 8'h7D, 8'h0D, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h1E, 8'h00, 8'h1F, 8'h00, 8'h1D, 8'h00, 8'h1C, 8'h00
    };

    // PS/2 set-2 make codes, indexed by key number.
    localparam logic [7:0] SCAN_TABLE [64] = '{
        8'h11, 8'h14, 8'h12, 8'h16, 8'h15, 8'h1C, 8'h1A, 8'h76,
        8'h26, 8'h1E, 8'h24, 8'h1D, 8'h23, 8'h1B, 8'h21, 8'h22,
        8'h2E, 8'h25, 8'h2C, 8'h2D, 8'h34, 8'h2B, 8'h32, 8'h2A,
        8'h3D, 8'h36, 8'h3C, 8'h35, 8'h3B, 8'h33, 8'h3A, 8'h31,
        8'h46, 8'h3E, 8'h44, 8'h43, 8'h4B, 8'h42, 8'h49, 8'h41,
        8'h4E, 8'h45, 8'h54, 8'h4D, 8'h52, 8'h4C, 8'h51, 8'h4A,
        8'h55, 8'h6A, 8'h5B, 8'h66, 8'h5D, 8'h5A, 8'h29, 8'h0E,
        8'h0D, 8'h83, 8'h0A, 8'h01, 8'h75, 8'h72, 8'h6B, 8'h74
    };

endpackage

[sv/kms_row_if.sv]
// Request channel that carries one row's sense byte into the scanner.
// No dependencies.
interface kms_row_if;
    logic       valid;
    logic       ready;
    logic [7:0] row_sense;

    modport source (output valid, output row_sense, input ready);
    modport sink (input valid, input row_sense, output ready);
endinterface

[sv/kms_evt_if.sv]
// Request channel that carries one key event out of the scanner.
// No dependencies.
interface kms_evt_if;
    logic       valid;
    logic       ready;
    logic [5:0] key_index;
    logic       is_break;
    logic [7:0] scan_code;
    logic       extended;
    logic       send_scan;
    logic [7:0] ascii_code;
    logic       last_event;

    modport source (output valid, output key_index, output is_break, output scan_code,
                    output extended, output send_scan, output ascii_code,
                    output last_event, input ready);
    modport sink (input valid, input key_index, input is_break, input scan_code,
                  input extended, input send_scan, input ascii_code,
                  input last_event, output ready);
endinterface

[sv/kms_front.sv]
// Front end: accepts row requests, debounces them against the previous scan
// of the row and queues the pressed columns. Depends on kms_pkg, kms_row_if.
module kms_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    kms_row_if.sink             i_row,
    input  logic                i_q_full,
    output logic                o_push,
    output kms_pkg::t_q_entry   o_entry
);

    logic [kms_pkg::ROW_W-1:0] r_row;
    logic [kms_pkg::ROW_W-1:0] n_row;
    logic [7:0]                r_prev [kms_pkg::ROW_SLOTS];
    logic [7:0]                changed;
    logic [7:0]                sense_eff;

    assign i_row.ready = !i_q_full;
    assign o_push      = i_row.valid && !i_q_full;

    always_comb begin
        changed   = r_prev[r_row] ^ i_row.row_sense;
        // A bit that moved since the last scan counts as released this time.
        sense_eff = i_row.row_sense | changed;
        for (int c = 0; c < 8; c++) begin
            o_entry.pressed[c] = !sense_eff[7-c];
        end
        o_entry.row = r_row;
        if (({1'b0, r_row} + 4'd1) >= 4'(kms_pkg::ROWS_USED)) begin
            n_row = '0;
        end else begin
            n_row = r_row + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            for (int r = 0; r < kms_pkg::ROW_SLOTS; r++) begin
                r_prev[r] <= 8'hFF;
            end
        end else if (o_push) begin
            r_row         <= n_row;
            r_prev[r_row] <= i_row.row_sense;
        end
    end

endmodule

[sv/kms_fifo.sv]
// Short queue of row scans between the front end and the back end.
// Depends on kms_pkg.
module kms_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kms_pkg::t_q_entry i_entry,
    output logic              o_full,
    output logic              o_valid,
    output kms_pkg::t_q_entry o_head,
    input  logic              i_pop
);

    kms_pkg::t_q_entry                r_mem [kms_pkg::QUEUE_DEPTH];
    logic [kms_pkg::QUEUE_PTR_W-1:0]  r_wr;
    logic [kms_pkg::QUEUE_PTR_W-1:0]  r_rd;
    logic [kms_pkg::QUEUE_PTR_W:0]    r_count;

    assign o_full  = (r_count == (kms_pkg::QUEUE_PTR_W + 1)'(kms_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/kms_back.sv]
// Back end: walks the queued row one column per cycle (a column with an event waits for
// a free output register), tracks held keys and the typematic accumulator, and drives
// the event output register. Depends on kms_pkg and kms_evt_if.
module kms_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  kms_pkg::t_q_entry i_q_head,
    output logic              o_q_pop,
    input  kms_pkg::t_cfg     i_cfg,
    kms_evt_if.source         o_evt
);

    logic [7:0]                 r_key_down [kms_pkg::ROW_SLOTS];
    logic [kms_pkg::ACC_W-1:0]  r_acc;
    logic [kms_pkg::COL_W-1:0]  r_col;
    logic                       r_out_valid;
    kms_pkg::t_event            r_out;

    logic [kms_pkg::ACC_W-1:0]  n_acc;
    logic [7:0]                 n_kd_row;
    logic [7:0]                 kd_row;
    logic [7:0]                 hi_mask;
    logic                       kd;
    logic                       pressed;
    logic                       has_event;
    logic                       out_free;
    logic                       advance;
    logic                       shift_held;
    logic [kms_pkg::KEY_W-1:0]  key;
    logic [kms_pkg::ACC_W:0]    sum;
    logic [kms_pkg::ACC_W-1:0]  sum_sat;
    logic [kms_pkg::ACC_W-1:0]  restart;
    logic [kms_pkg::ACC_W-1:0]  delay_ext;
    kms_pkg::t_event            evt;

    always_comb begin
        kd_row     = r_key_down[i_q_head.row];
        kd         = kd_row[r_col];
        pressed    = i_q_head.pressed[r_col];
        key        = {i_q_head.row, r_col};
        shift_held = r_key_down[0][kms_pkg::SHIFT_COL];
        has_event  = kd ^ pressed;
        out_free   = !r_out_valid || o_evt.ready;
        advance    = i_q_valid && (!has_event || out_free);
        o_q_pop    = advance && (r_col == '1);

        // Columns after this one whose state differs from the scan still owe an event.
        hi_mask    = ~((8'd2 << r_col) - 8'd1);

        delay_ext  = {4'b0, i_cfg.repeat_delay};
        sum        = {1'b0, r_acc} + {9'b0, i_cfg.time_step};
        sum_sat    = sum[kms_pkg::ACC_W] ? kms_pkg::ACC_MAX : sum[kms_pkg::ACC_W-1:0];
        if (i_cfg.repeat_delay > i_cfg.repeat_period) begin
            restart = {4'b0, i_cfg.repeat_delay - i_cfg.repeat_period};
        end else begin
            restart = '0;
        end

        n_acc    = r_acc;
        n_kd_row = kd_row;
        if (kd && pressed) begin
            if (key > kms_pkg::KEY_SHIFT) begin
                n_acc = sum_sat;
                if (sum_sat > delay_ext) begin
                    n_kd_row[r_col] = 1'b0;
                end
            end
        end else if (kd) begin
            n_kd_row[r_col] = 1'b0;
            n_acc           = '0;
        end else if (pressed) begin
            n_kd_row[r_col] = 1'b1;
            n_acc           = (r_acc > delay_ext) ? restart : '0;
        end

        evt.key_index  = key;
        evt.is_break   = kd;
        evt.scan_code  = kms_pkg::SCAN_TABLE[key];
        evt.extended   = (key >= kms_pkg::KEY_FIRST_EXT);
        evt.send_scan  = i_cfg.output_mode;
        evt.ascii_code = kd ? 8'h00 : kms_pkg::ASCII_TABLE[{key, shift_held}];
        evt.last_event = ((kd_row ^ i_q_head.pressed) & hi_mask) == 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < kms_pkg::ROW_SLOTS; r++) begin
                r_key_down[r] <= '0;
            end
            r_acc       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_key_down[i_q_head.row] <= n_kd_row;
                r_acc                    <= n_acc;
                r_col                    <= r_col + 1'b1;
            end
            if (advance && has_event) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_event) begin
            r_out <= evt;
        end
    end

    assign o_evt.valid      = r_out_valid;
    assign o_evt.key_index  = r_out.key_index;
    assign o_evt.is_break   = r_out.is_break;
    assign o_evt.scan_code  = r_out.scan_code;
    assign o_evt.extended   = r_out.extended;
    assign o_evt.send_scan  = r_out.send_scan;
    assign o_evt.ascii_code = r_out.ascii_code;
    assign o_evt.last_event = r_out.last_event;

endmodule

[sv/keyboard_matrix_scanner.sv]
// Keyboard matrix scanner top level: configuration registers, front end,
// row queue and back end. Depends on kms_pkg, kms_row_if, kms_evt_if and
// the kms_front, kms_fifo and kms_back modules.
//
// Each request on i_row carries the active-low sense byte of the next row of
// an 8x8 key matrix; rows are taken in order and wrap. The front end compares
// the byte with the previous scan of the same row and treats any bit that
// changed as released, which is the debounce. The back end then visits the
// row's eight keys, one key per clock cycle, pausing on any column whose
// event must wait for o_evt to take a pending event; that column walk is
// what sets the throughput. A newly pressed key gives a make event
// with its PS/2 set-2 code and ASCII character (shifted while key 2 is held),
// a released key gives a break event with ASCII code zero, and keys 60 to 63
// are flagged as extended. Keys above 2 that stay held feed a shared repeat
// accumulator, saturating at 65535, and make again once it passes the repeat
// delay. The last event caused by a row carries last_event. A two-entry queue
// sits between the front and back end; the row being walked stays in it until
// its last column is done, so one more row may be accepted ahead of it. The
// output register lets the walk go on over columns that cause no event while
// a finished event waits; a column that causes an event waits until the
// register is free. Configuration is written through i_cfg_we, i_cfg_idx and
// i_cfg_data and should only change while no row is in flight.
module keyboard_matrix_scanner (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    kms_row_if.sink                          i_row,
    kms_evt_if.source                        o_evt,
    input  logic                             i_cfg_we,
    input  logic [kms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    kms_pkg::t_cfg     r_cfg;
    kms_pkg::t_q_entry push_entry;
    kms_pkg::t_q_entry q_head;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    // Configuration registers; every index of the two-bit field names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_mode   <= 1'b0;
            r_cfg.repeat_delay  <= 12'd1200;
            r_cfg.repeat_period <= 12'd200;
            r_cfg.time_step     <= 8'd8;
        end else if (i_cfg_we) begin
            unique case (kms_pkg::t_cfg_idx'(i_cfg_idx))
                kms_pkg::CFG_OUTPUT_MODE: begin
                    r_cfg.output_mode <= i_cfg_data[0];
                end
                kms_pkg::CFG_REPEAT_DELAY: begin
                    r_cfg.repeat_delay <= i_cfg_data[11:0];
                end
                kms_pkg::CFG_REPEAT_PERIOD: begin
                    r_cfg.repeat_period <= i_cfg_data[11:0];
                end
                kms_pkg::CFG_TIME_STEP: begin
                    r_cfg.time_step <= i_cfg_data[7:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    kms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (i_row),
        .i_q_full(q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    kms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    kms_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_head (q_head),
        .o_q_pop  (q_pop),
        .i_cfg    (r_cfg),
        .o_evt    (o_evt)
    );

endmodule

[sv/kms_checker.sv]
// Port-level checks for the keyboard matrix scanner, bound to its top level.
// Depends only on the top level's ports.
module kms_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [5:0] i_key_index,
    input logic       i_is_break,
    input logic       i_extended,
    input logic [7:0] i_ascii_code,
    input logic       i_last_event
);

    // No event may be offered in the cycle after a reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("event offered right after reset");

    // A stalled event request stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("event request withdrawn while stalled");

    // A stalled event keeps its payload.
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_key_index) && $stable(i_is_break)
            && $stable(i_ascii_code) && $stable(i_last_event))
        else $error("event payload changed while stalled");

    // Break events never carry a character.
    a_break_no_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_break |-> i_ascii_code == 8'h00)
        else $error("break event with a character");

    // Only the top four keys carry the extended prefix.
    a_extended_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_extended == (i_key_index[5:2] == 4'hF))
        else $error("extended flag does not match key number");

endmodule

bind keyboard_matrix_scanner kms_checker u_kms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_key_index (o_evt.key_index),
    .i_is_break  (o_evt.is_break),
    .i_extended  (o_evt.extended),
    .i_ascii_code(o_evt.ascii_code),
    .i_last_event(o_evt.last_event)
);

[test/testbench.sv]
// Self-checking testbench for keyboard_matrix_scanner: row requests in, key events out.
// Depends on kms_pkg, the kms_row_if and kms_evt_if interfaces, and the scanner RTL.
module testbench;
    import kms_pkg::*;

    // A directed row: the sense byte to send and, where it is obvious from the
    // matrix state, the number of events it must cause and the first of them.
    typedef struct packed {
        logic [7:0] sense;
        logic       typed;
        logic [3:0] n_events;
        t_event     first;
    } t_row_case;

    localparam int IDLE_PCT       = 13;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 64;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_PRINTS     = 100;
    localparam int N_DIRECTED     = 24;

    // Three passes over the eight rows. The first pass only records the sense
    // bytes, since a bit that changed since the last scan counts as released.
    // The second pass repeats them, so the pressed keys make; the third pass
    // changes some rows, so those keys break, and holds others.
    localparam t_row_case DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b1, 4'd0, '0},
        '{8'hFF, 1'b1, 4'd0, '0},
        '{8'h55, 1'b1, 4'd0, '0},
        '{8'hAA, 1'b1, 4'd0, '0},
        '{8'h0F, 1'b1, 4'd0, '0},
        '{8'hF0, 1'b1, 4'd0, '0},
        '{8'hFE, 1'b1, 4'd0, '0},
        '{8'h00, 1'b1, 4'd0, '0},
        '{8'h00, 1'b1, 4'd8, '{6'd0, 1'b0, 8'h11, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{8'hFF, 1'b1, 4'd0, '0},
        '{8'h55, 1'b0, 4'd0, '0},
        '{8'hAA, 1'b0, 4'd0, '0},
        '{8'h0F, 1'b0, 4'd0, '0},
        '{8'hF0, 1'b0, 4'd0, '0},
        '{8'hFE, 1'b0, 4'd0, '0},
        '{8'h00, 1'b1, 4'd8, '{6'd56, 1'b0, 8'h0D, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{8'hFF, 1'b1, 4'd8, '{6'd0, 1'b1, 8'h11, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{8'h00, 1'b1, 4'd0, '0},
        '{8'h55, 1'b0, 4'd0, '0},
        '{8'h55, 1'b0, 4'd0, '0},
        '{8'hF0, 1'b0, 4'd0, '0},
        '{8'hF0, 1'b0, 4'd0, '0},
        '{8'h7F, 1'b1, 4'd1, '{6'd55, 1'b1, 8'h0E, 1'b0, 1'b0, 8'h00, 1'b1}},
        '{8'h0F, 1'b0, 4'd0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    kms_row_if row_ch ();
    kms_evt_if evt_ch ();

    keyboard_matrix_scanner dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_row      (row_ch),
        .o_evt      (evt_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predicted matrix state, kept in step with every accepted row request.
    logic [7:0]  held_keys [8];
    logic [7:0]  last_sense [8];
    logic [2:0]  scan_row;
    logic [15:0] repeat_acc;
    logic        cfg_mode;
    logic [11:0] cfg_delay;
    logic [11:0] cfg_period;
    logic [7:0]  cfg_step;

    // Events that the scanner still owes, oldest first.
    t_event expected_events [$];

    // Stimulus-side view of the switches: the level each row is held at.
    logic [7:0] switch_level [8];

    int  errors;
    int  cycle_count;
    bit  steady;          // when set, neither side idles
    int  holdoff_req;     // bumped by the stimulus to ask for a long output stall
    int  holdoff_served;
    int  holdoff_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string msg);
        if (errors < MAX_PRINTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        errors++;
    endtask

    function automatic t_event key_event(input logic [5:0] key, input logic brk,
                                         input logic [7:0] ascii);
        t_event ev;
        ev.key_index  = key;
        ev.is_break   = brk;
        ev.scan_code  = SCAN_TABLE[key];
        ev.extended   = (key >= KEY_FIRST_EXT);
        ev.send_scan  = cfg_mode;
        ev.ascii_code = ascii;
        ev.last_event = 1'b0;
        return ev;
    endfunction

    // Walks one row the way the scanner does: debounce against the previous
    // scan, then make, break or typematic repeat per column, MSB first.
    function automatic void predict_row_events(input logic [7:0] sense_in,
                                               output int count, output t_event first_ev);
        logic [2:0]  row;
        logic [7:0]  sense;
        logic [7:0]  mask;
        logic [5:0]  key;
        logic [6:0]  slot;
        logic [16:0] sum;
        t_event      row_events [$];
        row = scan_row;
        // Any bit that moved since the last visit is taken as released.
        sense = sense_in | (last_sense[row] ^ sense_in);
        last_sense[row] = sense_in;
        for (int col = 0; col < 8; col++) begin
            mask = 8'h80 >> col;
            key  = {row, 3'(col)};
            if ((held_keys[row] & mask) != 0) begin
                if ((sense & mask) == 0) begin
                    // Held: modifiers never repeat, the rest feed the accumulator.
                    if (key > KEY_SHIFT) begin
                        sum = {1'b0, repeat_acc} + {9'b0, cfg_step};
                        repeat_acc = (sum > 17'h0FFFF) ? ACC_MAX : sum[15:0];
                        if (repeat_acc > {4'b0, cfg_delay}) begin
                            held_keys[row] = held_keys[row] & ~mask;
                        end
                    end
                end else begin
                    row_events.push_back(key_event(key, 1'b1, 8'h00));
                    held_keys[row] = held_keys[row] & ~mask;
                    repeat_acc = '0;
                end
            end else if ((sense & mask) == 0) begin
                slot = {key, ((held_keys[0] & (8'h80 >> SHIFT_COL)) != 0)};
                row_events.push_back(key_event(key, 1'b0, ASCII_TABLE[slot]));
                held_keys[row] = held_keys[row] | mask;
                if (repeat_acc > {4'b0, cfg_delay}) begin
                    repeat_acc = (cfg_delay > cfg_period) ? {4'b0, cfg_delay - cfg_period} : '0;
                end else begin
                    repeat_acc = '0;
                end
            end
        end
        count = row_events.size();
        first_ev = '0;
        if (count > 0) begin
            row_events[count - 1].last_event = 1'b1;
            first_ev = row_events[0];
        end
        foreach (row_events[i]) begin
            expected_events.push_back(row_events[i]);
        end
        scan_row = (int'(row) + 1 >= ROWS_USED) ? 3'd0 : row + 3'd1;
    endfunction

    // Offers one row request, with random gaps before it, and predicts its
    // events once the scanner takes it. Valid is left high for the next call.
    task automatic send_row(input logic [7:0] sense, output int count, output t_event first_ev);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            row_ch.valid <= 1'b0;
            @(posedge clk);
        end
        row_ch.valid     <= 1'b1;
        row_ch.row_sense <= sense;
        do @(posedge clk); while (!row_ch.ready);
        predict_row_events(sense, count, first_ev);
    endtask

    // Stops offering rows until every owed event has arrived, then gives the
    // row queue and the column walk time to empty out on rows with no events.
    task automatic drain_and_settle();
        row_ch.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers back to back; only called while idle.
    task automatic apply_settings(input logic mode, input logic [11:0] delay,
                                  input logic [11:0] period, input logic [7:0] step);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_OUTPUT_MODE;
        cfg_data <= {11'b0, mode};
        @(posedge clk);
        cfg_idx  <= CFG_REPEAT_DELAY;
        cfg_data <= delay;
        @(posedge clk);
        cfg_idx  <= CFG_REPEAT_PERIOD;
        cfg_data <= period;
        @(posedge clk);
        cfg_idx  <= CFG_TIME_STEP;
        cfg_data <= {4'b0, step};
        @(posedge clk);
        cfg_we     <= 1'b0;
        cfg_mode   = mode;
        cfg_delay  = delay;
        cfg_period = period;
        cfg_step   = step;
    endtask

    // Mostly the held switch levels are sent again, which is what lets keys
    // make, stay down and repeat. Some visits flip one or two switches, and a
    // few send a random byte that does not change the held levels.
    task automatic run_random_rows(input int n_rows);
        int         pick;
        int         count;
        t_event     first_ev;
        logic [7:0] sense;
        for (int i = 0; i < n_rows; i++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                sense = 8'($urandom);
            end else begin
                if (pick < 30) begin
                    switch_level[scan_row] ^= 8'(1 << $urandom_range(7));
                    if (pick < 15) switch_level[scan_row] ^= 8'(1 << $urandom_range(7));
                end
                sense = switch_level[scan_row];
            end
            send_row(sense, count, first_ev);
        end
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want, input t_event exp_ev);
        if (got != want) begin
            report($sformatf("key %0d %s: got 0x%0h, expected 0x%0h",
                             exp_ev.key_index, name, got, want));
        end
    endtask

    // Event sink: checks each accepted event against the oldest prediction and
    // decides ready for the next edge. A long hold-off, when requested, is
    // counted here so the sender keeps pushing rows into a full scanner.
    initial begin
        t_event got;
        t_event want;
        evt_ch.ready   = 1'b0;
        holdoff_served = 0;
        holdoff_left   = 0;
        forever begin
            @(posedge clk);
            if (rst_n && evt_ch.valid && evt_ch.ready) begin
                got.key_index  = evt_ch.key_index;
                got.is_break   = evt_ch.is_break;
                got.scan_code  = evt_ch.scan_code;
                got.extended   = evt_ch.extended;
                got.send_scan  = evt_ch.send_scan;
                got.ascii_code = evt_ch.ascii_code;
                got.last_event = evt_ch.last_event;
                if (expected_events.size() == 0) begin
                    report($sformatf("event for key %0d with none expected", got.key_index));
                end else begin
                    want = expected_events.pop_front();
                    check_field("key_index", got.key_index, want.key_index, want);
                    check_field("is_break", got.is_break, want.is_break, want);
                    check_field("scan_code", got.scan_code, want.scan_code, want);
                    check_field("extended", got.extended, want.extended, want);
                    check_field("send_scan", got.send_scan, want.send_scan, want);
                    check_field("ascii_code", got.ascii_code, want.ascii_code, want);
                    check_field("last_event", got.last_event, want.last_event, want);
                end
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                evt_ch.ready <= 1'b0;
            end else if (holdoff_served != holdoff_req) begin
                holdoff_served++;
                holdoff_left = HOLDOFF_CYCLES;
                evt_ch.ready <= 1'b0;
            end else begin
                evt_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[keyboard_matrix_scanner] ERROR");
        $finish;
    end

    initial begin
        int     count;
        t_event first_ev;
        errors           = 0;
        steady           = 1'b0;
        holdoff_req      = 0;
        rst_n            = 1'b0;
        row_ch.valid     = 1'b0;
        row_ch.row_sense = 8'hFF;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_OUTPUT_MODE;
        cfg_data         = '0;

        // Predictor state after reset, with the register reset values.
        foreach (held_keys[r]) begin
            held_keys[r]  = 8'h00;
            last_sense[r] = 8'hFF;
        end
        scan_row   = '0;
        repeat_acc = '0;
        cfg_mode   = 1'b0;
        cfg_delay  = 12'd1200;
        cfg_period = 12'd200;
        cfg_step   = 8'd8;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows under the reset settings. Where a row has typed
        // expectations, the prediction must agree with them as well.
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_row(DIRECTED[i].sense, count, first_ev);
            if (DIRECTED[i].typed) begin
                if (count != DIRECTED[i].n_events) begin
                    report($sformatf("directed row %0d: %0d events predicted, %0d typed",
                                     i, count, DIRECTED[i].n_events));
                end else if (count > 0 && first_ev != DIRECTED[i].first) begin
                    report($sformatf("directed row %0d: first event differs from typed", i));
                end
            end
        end
        foreach (switch_level[r]) switch_level[r] = last_sense[r];

        run_random_rows(40);
        drain_and_settle();

        // Lowest delay, period and step: held keys repeat almost every visit,
        // so rows cause many events. The output stalls for a long stretch at
        // the start while rows keep coming, which backs the scanner up.
        apply_settings(1'b1, 12'd0, 12'd0, 8'd1);
        holdoff_req <= holdoff_req + 1;
        run_random_rows(60);
        drain_and_settle();

        // Highest settings, with no idling on either side.
        apply_settings(1'b0, 12'd4095, 12'd4095, 8'd255);
        steady <= 1'b1;
        run_random_rows(60);
        steady <= 1'b0;
        drain_and_settle();

        // A period longer than the delay, so a repeat restarts the accumulator at zero.
        apply_settings(1'b1, 12'd100, 12'd300, 8'd37);
        run_random_rows(60);
        drain_and_settle();

        apply_settings(1'($urandom), 12'($urandom_range(600)), 12'($urandom_range(4095)),
                       8'($urandom_range(255, 1)));
        run_random_rows(76);
        drain_and_settle();

        if (errors == 0) begin
            $display("[keyboard_matrix_scanner] OK");
        end else begin
            $display("[keyboard_matrix_scanner] ERROR");
        end
        $finish;
    end

endmodule
